// ----- sv/mbc_pkg.sv -----
// Shared types and constants for the modular binomial coefficient core.
// Holds the query and result word formats and the Barrett reduction constants.
// No dependencies; every other file imports this package.
package mbc_pkg;

    // Field widths of the query and result words.
    localparam int ADDR_W = 10;
    localparam int MOD_W  = 30;

    // Table depth follows the index width.
    localparam int TABLE_DEPTH = 1 << ADDR_W;

    // Prime modulus and its Fermat exponent p - 2.
    localparam longint unsigned PRIME_MODULUS = 64'd1000000007;
    localparam logic [MOD_W-1:0] FERMAT_EXP = MOD_W'(PRIME_MODULUS - 64'd2);

    // Barrett constant floor(2^(2*MOD_W) / p); it needs MOD_W + 1 bits.
    localparam int EST_W = MOD_W + 1;
    localparam longint unsigned BARRETT_MU = (64'd1 << (2 * MOD_W)) / PRIME_MODULUS;

    // Register stages in one modular multiplier.
    localparam int MUL_LAT = 5;

    // Result queue depth; it covers the pipeline latency with room to spare.
    localparam int Q_DEPTH = 16;
    localparam int Q_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [ADDR_W-1:0] top;
        logic [ADDR_W-1:0] pick;
    } query_t;

    typedef struct packed {
        logic [MOD_W-1:0] value;
        logic             bad_args;
    } result_t;

endpackage

// ----- sv/mbc_modmul.sv -----
// Pipelined modular multiplier: product = a * b mod p, Barrett reduction.
// Five register stages, one new operand pair per cycle.
// Depends on mbc_pkg for the modulus, widths and Barrett constant.
module mbc_modmul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mbc_pkg::MOD_W-1:0] a,
    input  logic [mbc_pkg::MOD_W-1:0] b,
    output logic                     done,
    output logic [mbc_pkg::MOD_W-1:0] product
);
    import mbc_pkg::*;

    localparam int PROD_W = 2 * MOD_W;
    localparam int LO_W   = MOD_W + 2;
    localparam int QP_W   = EST_W + MOD_W;

    logic [MUL_LAT-1:0] vld_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [2*EST_W-1:0] est_reg;
    logic [LO_W-1:0]    lo2_reg;
    logic [LO_W-1:0]    lo3_reg;
    logic [LO_W-1:0]    qp_reg;
    logic [LO_W-1:0]    rem_reg;
    logic [MOD_W-1:0]   product_reg;
    logic [EST_W-1:0]   quot;
    logic [QP_W-1:0]    qp_full;

    // The quotient estimate is at most two below the true quotient.
    assign quot    = est_reg[2*EST_W-1:MOD_W+1];
    assign qp_full = QP_W'(quot) * QP_W'(PRIME_MODULUS);

    // Valid flags follow the operands through the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[MUL_LAT-2:0], start};
        end
    end

    // Datapath: full product, quotient estimate, q * p, remainder, correction.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);

        est_reg <= (2*EST_W)'(prod_reg[PROD_W-1:MOD_W-1]) * (2*EST_W)'(BARRETT_MU);
        lo2_reg <= prod_reg[LO_W-1:0];

        qp_reg  <= qp_full[LO_W-1:0];
        lo3_reg <= lo2_reg;

        // The true remainder is below 3p, so the low bits are enough.
        rem_reg <= lo3_reg - qp_reg;

        if (rem_reg >= LO_W'(2 * PRIME_MODULUS))
        begin
            product_reg <= MOD_W'(rem_reg - LO_W'(2 * PRIME_MODULUS));
        end
        else if (rem_reg >= LO_W'(PRIME_MODULUS))
        begin
            product_reg <= MOD_W'(rem_reg - LO_W'(PRIME_MODULUS));
        end
        else
        begin
            product_reg <= MOD_W'(rem_reg);
        end
    end

    assign done    = vld_reg[MUL_LAT-1];
    assign product = product_reg;

endmodule

// ----- sv/modular_binomial_coefficient_core.sv -----
// Binomial coefficient C(n, r) mod 1e9+7 from factorial and inverse-factorial tables.
//
// Usage: a query word {top, pick} enters on the query channel (query_valid /
// query_stall); one result word {value, bad_args} leaves on the result channel
// (result_valid / result_stall) for every query, in order. A word moves at a
// rising edge where valid is high and stall is low.
//
// Throughput is one query per cycle while query_stall is low. A result is offered
// once its query has passed the table read register, then two chained modular
// multipliers of five stages each, then the result queue.
//
// After reset the block fills its tables and holds query_stall high meanwhile:
// k! by repeated multiplication, the inverse of 1023! by square-and-multiply,
// then the inverse factorials downward. Each step waits for one multiplier
// pass.
//
// A 16-word result queue sits after the pipeline, and queries are admitted only
// while a queue slot is reserved for them; a stalled receiver therefore stalls
// the query side only once 16 words are outstanding. When pick exceeds top the
// result is value 0 with bad_args set.
module modular_binomial_coefficient_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  mbc_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_stall,
    output mbc_pkg::result_t result
);
    import mbc_pkg::*;

    localparam int BIT_W = $clog2(MOD_W);

    typedef enum logic [8:0] {
        ST_INIT      = 9'b000000001,
        ST_FACT_ISS  = 9'b000000010,
        ST_FACT_WAIT = 9'b000000100,
        ST_EXP_ISS   = 9'b000001000,
        ST_EXP_WAIT  = 9'b000010000,
        ST_INV_START = 9'b000100000,
        ST_INV_ISS   = 9'b001000000,
        ST_INV_WAIT  = 9'b010000000,
        ST_RUN       = 9'b100000000
    } fill_state_t;

    // Fill sequencer state.
    fill_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [MOD_W-1:0]  acc_reg, acc_next;
    logic [MOD_W-1:0]  base_reg, base_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;

    // Tables and their write ports.
    logic [MOD_W-1:0]  fact_mem [TABLE_DEPTH];
    logic [MOD_W-1:0]  invf_mem [TABLE_DEPTH];
    logic              fact_we;
    logic [ADDR_W-1:0] fact_waddr;
    logic [MOD_W-1:0]  fact_wdata;
    logic              invf_we;
    logic [ADDR_W-1:0] invf_waddr;
    logic [MOD_W-1:0]  invf_wdata;

    // Query pipeline.
    logic              running;
    logic              accept;
    logic [ADDR_W-1:0] diff_addr;
    logic              s1_valid_reg;
    logic              s1_bad_reg;
    logic [MOD_W-1:0]  fact_rd_reg;
    logic [MOD_W-1:0]  invr_rd_reg;
    logic [MOD_W-1:0]  invnr_rd_reg;
    logic [MOD_W-1:0]  invnr_dly_reg [MUL_LAT];
    logic              bad_dly_reg [2*MUL_LAT];

    // Shared multipliers.
    logic              mm1_start, mm1_done;
    logic [MOD_W-1:0]  mm1_a, mm1_b, mm1_prod;
    logic              mm2_start, mm2_done;
    logic [MOD_W-1:0]  mm2_a, mm2_b, mm2_prod;

    // Result queue and admission credits.
    result_t           q_reg [Q_DEPTH];
    logic [Q_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] q_count_reg;
    logic [QCNT_W-1:0] credit_reg;
    logic              push, pop;
    result_t           push_word;

    assign running     = (state_reg == ST_RUN);
    assign query_stall = !running || (credit_reg == QCNT_W'(Q_DEPTH));
    assign accept      = query_valid && !query_stall;
    assign diff_addr   = query.top - query.pick;

    // Fill sequencer: next state, running values and table writes.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        bit_next   = bit_reg;
        fact_we    = 1'b0;
        fact_waddr = k_reg;
        fact_wdata = mm1_prod;
        invf_we    = 1'b0;
        invf_waddr = k_reg - ADDR_W'(1);
        invf_wdata = mm1_prod;
        case (state_reg)
            ST_INIT:
            begin
                fact_we    = 1'b1;
                fact_waddr = '0;
                fact_wdata = MOD_W'(1);
                acc_next   = MOD_W'(1);
                k_next     = ADDR_W'(1);
                state_next = ST_FACT_ISS;
            end
            ST_FACT_ISS:
            begin
                state_next = ST_FACT_WAIT;
            end
            ST_FACT_WAIT:
            begin
                if (mm1_done)
                begin
                    fact_we  = 1'b1;
                    acc_next = mm1_prod;
                    if (k_reg == ADDR_W'(TABLE_DEPTH - 1))
                    begin
                        base_next  = mm1_prod;
                        acc_next   = MOD_W'(1);
                        bit_next   = '0;
                        state_next = ST_EXP_ISS;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_FACT_ISS;
                    end
                end
            end
            ST_EXP_ISS:
            begin
                state_next = ST_EXP_WAIT;
            end
            ST_EXP_WAIT:
            begin
                if (mm1_done)
                begin
                    acc_next  = mm1_prod;
                    base_next = mm2_prod;
                    if (bit_reg == BIT_W'(MOD_W - 1))
                    begin
                        state_next = ST_INV_START;
                    end
                    else
                    begin
                        bit_next   = bit_reg + BIT_W'(1);
                        state_next = ST_EXP_ISS;
                    end
                end
            end
            ST_INV_START:
            begin
                // The top entry holds the inverse of the largest factorial.
                invf_we    = 1'b1;
                invf_waddr = k_reg;
                invf_wdata = acc_reg;
                state_next = ST_INV_ISS;
            end
            ST_INV_ISS:
            begin
                state_next = ST_INV_WAIT;
            end
            ST_INV_WAIT:
            begin
                if (mm1_done)
                begin
                    invf_we  = 1'b1;
                    acc_next = mm1_prod;
                    if (k_reg == ADDR_W'(1))
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        k_next     = k_reg - ADDR_W'(1);
                        state_next = ST_INV_ISS;
                    end
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            k_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
    end

    // Factorial table: written during the fill, read at top for each query.
    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[fact_waddr] <= fact_wdata;
        end
        fact_rd_reg <= fact_mem[query.top];
    end

    // Inverse-factorial table: read at pick and at top - pick.
    always_ff @(posedge clk)
    begin
        if (invf_we)
        begin
            invf_mem[invf_waddr] <= invf_wdata;
        end
        invr_rd_reg  <= invf_mem[query.pick];
        invnr_rd_reg <= invf_mem[diff_addr];
    end

    // Read stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // Side data rides alongside the multipliers; the pipeline never stalls.
    always_ff @(posedge clk)
    begin
        s1_bad_reg <= (query.pick > query.top);
        invnr_dly_reg[0] <= invnr_rd_reg;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            invnr_dly_reg[i] <= invnr_dly_reg[i-1];
        end
        bad_dly_reg[0] <= s1_bad_reg;
        for (int i = 1; i < 2 * MUL_LAT; i++)
        begin
            bad_dly_reg[i] <= bad_dly_reg[i-1];
        end
    end

    // Multiplier operands: query datapath when running, fill steps otherwise.
    always_comb
    begin
        if (running)
        begin
            mm1_start = s1_valid_reg;
            mm1_a     = fact_rd_reg;
            mm1_b     = invr_rd_reg;
            mm2_start = mm1_done;
            mm2_a     = mm1_prod;
            mm2_b     = invnr_dly_reg[MUL_LAT-1];
        end
        else
        begin
            mm1_start = (state_reg == ST_FACT_ISS) || (state_reg == ST_EXP_ISS) ||
                        (state_reg == ST_INV_ISS);
            mm1_a     = acc_reg;
            mm1_b     = MOD_W'(k_reg);
            if (state_reg == ST_EXP_ISS)
            begin
                mm1_b = FERMAT_EXP[bit_reg] ? base_reg : MOD_W'(1);
            end
            mm2_start = (state_reg == ST_EXP_ISS);
            mm2_a     = base_reg;
            mm2_b     = base_reg;
        end
    end

    mbc_modmul u_mul_first (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm1_start),
        .a       (mm1_a),
        .b       (mm1_b),
        .done    (mm1_done),
        .product (mm1_prod)
    );

    mbc_modmul u_mul_second (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm2_start),
        .a       (mm2_a),
        .b       (mm2_b),
        .done    (mm2_done),
        .product (mm2_prod)
    );

    // Finished words enter the result queue.
    assign push               = running && mm2_done;
    assign pop                = result_valid && !result_stall;
    assign push_word.bad_args = bad_dly_reg[2*MUL_LAT-1];
    assign push_word.value    = bad_dly_reg[2*MUL_LAT-1] ? '0 : mm2_prod;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Queue pointers, occupancy and outstanding-query credits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            credit_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_W'(1);
            end
            q_count_reg <= q_count_reg + QCNT_W'(push) - QCNT_W'(pop);
            credit_reg  <= credit_reg + QCNT_W'(accept) - QCNT_W'(pop);
        end
    end

    assign result_valid = (q_count_reg != '0);
    assign result       = q_reg[rd_ptr_reg];

endmodule
